>>> design/hts_pkg.sv
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types, field widths, register indexes and defaults of the heightmap
// triangle sampler.
// ----------------------------------------------------------------------------
package hts_pkg;

   // Parameter defaults
   localparam int DEF_MAX_CELLS_X = 64;
   localparam int DEF_MAX_CELLS_Y = 64;
   localparam int DEF_FRAC_BITS   = 16;

   // Fixed field widths
   localparam int POS_W    = 22;
   localparam int VERT_W   = 7;
   localparam int HEIGHT_W = 8;
   localparam int Z_W      = 24;
   localparam int GRID_W   = 7;
   localparam int SCALE_W  = 16;

   // Register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_GRID_X = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_GRID_Y = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_SCALE  = 2'd2;

   localparam logic [GRID_W-1:0]  GRID_X_RESET = 7'd64;
   localparam logic [GRID_W-1:0]  GRID_Y_RESET = 7'd64;
   localparam logic [SCALE_W-1:0] SCALE_RESET  = 16'd3277;

   // Operation codes of an input item
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_SAMPLE,
      CMD_OFF_MAP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic                  tri_upper;
      logic [POS_W-1:0]      pos_x;
      logic [POS_W-1:0]      pos_y;
      logic [VERT_W-1:0]     vert_col;
      logic [VERT_W-1:0]     vert_row;
      logic [HEIGHT_W-1:0]   vert_height;
   } cmd_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_RD1,
      B_RD2,
      B_ACC,
      B_SCALE
   } back_state_type;

endpackage

>>> design/hts_req_if.sv
// ----------------------------------------------------------------------------
// hts_req_if
// Input item channel: valid/ready handshake with write and sample fields.
// ----------------------------------------------------------------------------
interface hts_req_if import hts_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  operation;
   logic [POS_W-1:0]      pos_x;
   logic [POS_W-1:0]      pos_y;
   logic [VERT_W-1:0]     vert_col;
   logic [VERT_W-1:0]     vert_row;
   logic [HEIGHT_W-1:0]   vert_height;

   modport source (output valid, operation, pos_x, pos_y, vert_col, vert_row,
                   vert_height, input ready);
   modport sink   (input valid, operation, pos_x, pos_y, vert_col, vert_row,
                   vert_height, output ready);
endinterface

>>> design/hts_rsp_if.sv
// ----------------------------------------------------------------------------
// hts_rsp_if
// Result item channel: valid/ready handshake with terrain height and flag.
// ----------------------------------------------------------------------------
interface hts_rsp_if import hts_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [Z_W-1:0]   terrain_z;
   logic             off_map;

   modport source (output valid, terrain_z, off_map, input ready);
   modport sink   (input valid, terrain_z, off_map, output ready);
endinterface

>>> design/hts_ram.sv
// ----------------------------------------------------------------------------
// hts_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module hts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4225
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write on enable, register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/hts_queue.sv
// ----------------------------------------------------------------------------
// hts_queue
// Short command FIFO decoupling the classifying front from the back end.
// ----------------------------------------------------------------------------
module hts_queue import hts_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output cmd_type pop_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type             slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign valid   = (count_ff != '0);
   assign pop_cmd = slot_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> design/hts_front.sv
// ----------------------------------------------------------------------------
// hts_front
// Accepts input items and classifies them: in-grid vertex writes, samples on
// the map (with triangle choice) and samples off the map. Drops writes that
// fall outside the active grid.
// ----------------------------------------------------------------------------
module hts_front import hts_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   hts_req_if.sink            req,
   input  logic [GRID_W-1:0]  grid_x,
   input  logic [GRID_W-1:0]  grid_y,
   input  logic               q_full,
   output logic               push,
   output cmd_type            push_cmd
);

   logic [POS_W-1:0]     cell_x;
   logic [POS_W-1:0]     cell_y;
   logic [FRAC_BITS-1:0] frac_x;
   logic [FRAC_BITS-1:0] frac_y;
   logic                 write_in_grid;
   logic                 sample_off;

   assign req.ready = !q_full;

   // Split position into cell index and fraction
   assign cell_x = req.pos_x >> FRAC_BITS;
   assign cell_y = req.pos_y >> FRAC_BITS;
   assign frac_x = FRAC_BITS'(req.pos_x);
   assign frac_y = FRAC_BITS'(req.pos_y);

   assign write_in_grid = (req.vert_col <= grid_x) && (req.vert_row <= grid_y);
   assign sample_off    = (cell_x >= POS_W'(grid_x)) || (cell_y >= POS_W'(grid_y));

   // Classify the item
   always_comb begin
      push_cmd.tri_upper   = !(frac_x > frac_y);
      push_cmd.pos_x       = req.pos_x;
      push_cmd.pos_y       = req.pos_y;
      push_cmd.vert_col    = req.vert_col;
      push_cmd.vert_row    = req.vert_row;
      push_cmd.vert_height = req.vert_height;
      if (req.operation == OP_WRITE) begin
         push_cmd.kind = CMD_WRITE;
      end else if (sample_off) begin
         push_cmd.kind = CMD_OFF_MAP;
      end else begin
         push_cmd.kind = CMD_SAMPLE;
      end
   end

   // Drop writes outside the grid
   assign push = req.valid && !q_full &&
                 ((req.operation == OP_SAMPLE) || write_in_grid);

endmodule

>>> design/hts_back.sv
// ----------------------------------------------------------------------------
// hts_back
// Carries out queued commands against the height memory: stores vertex
// writes, reads three triangle corners one per cycle, accumulates the
// weighted sum, scales it and holds the result in an output register.
// ----------------------------------------------------------------------------
module hts_back import hts_pkg::*; #(
   parameter int MAX_CELLS_X = DEF_MAX_CELLS_X,
   parameter int MAX_CELLS_Y = DEF_MAX_CELLS_Y,
   parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [SCALE_W-1:0] scale,
   input  logic               q_valid,
   input  cmd_type            q_cmd,
   output logic               q_pop,
   hts_rsp_if.source          rsp
);

   localparam int STRIDE = MAX_CELLS_X + 1;
   localparam int DEPTH  = (MAX_CELLS_X + 1) * (MAX_CELLS_Y + 1);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CELL_W = GRID_W + 1;
   localparam int WGT_W  = FRAC_BITS + 1;
   localparam int ACC_W  = HEIGHT_W + FRAC_BITS;
   localparam int PROD_W = ACC_W + SCALE_W;
   localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << FRAC_BITS;

   back_state_type        state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   cmd_type               cur;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic                  out_valid_ff, out_valid_in;
   logic [Z_W-1:0]        out_z_ff, out_z_in;
   logic                  out_off_ff, out_off_in;

   logic [CELL_W-1:0]     cx, cy;
   logic [FRAC_BITS-1:0]  fx, fy;
   logic [ADDR_W-1:0]     addr_c0, addr_c1, addr_c2, addr_wr;
   logic [ADDR_W-1:0]     ram_addr;
   logic                  ram_we;
   logic [HEIGHT_W-1:0]   ram_rdata;
   logic [WGT_W-1:0]      w0, w1, w2, weight;
   logic [ACC_W-1:0]      term;
   logic [PROD_W-1:0]     z_prod;
   logic                  out_free;
   logic                  load_z;
   logic                  load_off;

   function automatic logic [ADDR_W-1:0] vert_addr(input logic [CELL_W-1:0] col,
                                                   input logic [CELL_W-1:0] row);
      vert_addr = ADDR_W'(row) * ADDR_W'(STRIDE) + ADDR_W'(col);
   endfunction

   // Corner addresses and weights of the current command
   assign cur = (state_ff == B_IDLE) ? q_cmd : cmd_ff;
   assign cx  = CELL_W'(cur.pos_x >> FRAC_BITS);
   assign cy  = CELL_W'(cur.pos_y >> FRAC_BITS);
   assign fx  = FRAC_BITS'(cur.pos_x);
   assign fy  = FRAC_BITS'(cur.pos_y);

   assign addr_c0 = vert_addr(cx, cy);
   assign addr_c1 = cur.tri_upper ? vert_addr(cx, cy + 1'b1) : vert_addr(cx + 1'b1, cy);
   assign addr_c2 = vert_addr(cx + 1'b1, cy + 1'b1);
   assign addr_wr = vert_addr(CELL_W'(cur.vert_col), CELL_W'(cur.vert_row));

   assign w0 = cur.tri_upper ? WGT_ONE - WGT_W'(fy) : WGT_ONE - WGT_W'(fx);
   assign w1 = cur.tri_upper ? WGT_W'(fy) - WGT_W'(fx) : WGT_W'(fx) - WGT_W'(fy);
   assign w2 = cur.tri_upper ? WGT_W'(fx) : WGT_W'(fy);

   assign out_free = !out_valid_ff || rsp.ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (q_valid && (q_cmd.kind == CMD_SAMPLE)) begin
               state_in = B_RD1;
            end
         end
         B_RD1:   state_in = B_RD2;
         B_RD2:   state_in = B_ACC;
         B_ACC:   state_in = B_SCALE;
         B_SCALE: begin
            if (out_free) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // Control outputs per state
   always_comb begin
      q_pop    = 1'b0;
      ram_we   = 1'b0;
      load_z   = 1'b0;
      load_off = 1'b0;
      ram_addr = addr_c0;
      weight   = w0;
      unique case (state_ff)
         B_IDLE: begin
            if (q_cmd.kind == CMD_WRITE) begin
               ram_addr = addr_wr;
            end
            if (q_valid) begin
               ram_we   = (q_cmd.kind == CMD_WRITE);
               load_off = (q_cmd.kind == CMD_OFF_MAP) && out_free;
               q_pop    = (q_cmd.kind != CMD_OFF_MAP) || out_free;
            end
         end
         B_RD1: begin
            ram_addr = addr_c1;
            weight   = w0;
         end
         B_RD2: begin
            ram_addr = addr_c2;
            weight   = w1;
         end
         B_ACC: begin
            weight = w2;
         end
         B_SCALE: begin
            load_z = out_free;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   hts_ram #(
      .WIDTH (HEIGHT_W),
      .DEPTH (DEPTH)
   ) u_heights (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (cur.vert_height),
      .rd_data (ram_rdata)
   );

   // Weighted corner sum
   assign term = ACC_W'(ram_rdata) * ACC_W'(weight);

   always_comb begin
      acc_in = acc_ff;
      cmd_in = cmd_ff;
      if (q_pop) begin
         cmd_in = q_cmd;
      end
      if (state_ff == B_RD1) begin
         acc_in = term;
      end else if ((state_ff == B_RD2) || (state_ff == B_ACC)) begin
         acc_in = acc_ff + term;
      end
   end

   // Scale by world height per unit
   assign z_prod = PROD_W'(acc_ff) * PROD_W'(scale);

   // Output register: load a result, drop it once taken
   always_comb begin
      out_valid_in = out_valid_ff;
      out_z_in     = out_z_ff;
      out_off_in   = out_off_ff;
      if (load_z) begin
         out_valid_in = 1'b1;
         out_z_in     = Z_W'(z_prod >> FRAC_BITS);
         out_off_in   = 1'b0;
      end else if (load_off) begin
         out_valid_in = 1'b1;
         out_z_in     = '0;
         out_off_in   = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      acc_ff     <= acc_in;
      out_z_ff   <= out_z_in;
      out_off_ff <= out_off_in;
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.terrain_z = out_z_ff;
   assign rsp.off_map   = out_off_ff;

endmodule

>>> design/heightmap_triangle_sampler.sv
// ----------------------------------------------------------------------------
// heightmap_triangle_sampler
// Vertex height grid with triangle interpolation and height scaling.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+------------------------------
//   req_chan | in        | valid / ready        | operation, pos, vertex, height
//   rsp_chan | out       | valid / ready        | terrain_z, off_map
//   csr_*    | in / out  | APB r/w, pready=1    | grid_cells_x/y, height scale
//
// A sample on the map steps through the back end states IDLE, RD1, RD2, ACC
// and SCALE: the three corner heights come from one single-port memory at
// one read per cycle, then the weighted sum is scaled by one multiply. A
// vertex write or an off-map sample is handled in IDLE. A two-entry command
// queue lets the front accept items while the back end works or a result
// waits in the output register. Reset is synchronous and clears control
// state only; the height memory is not cleared and holds no valid bits.
// ----------------------------------------------------------------------------
module heightmap_triangle_sampler import hts_pkg::*; #(
   parameter int MAX_CELLS_X = DEF_MAX_CELLS_X,
   parameter int MAX_CELLS_Y = DEF_MAX_CELLS_Y,
   parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   hts_req_if.sink               req_chan,
   hts_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [GRID_W-1:0]    grid_x_ff, grid_x_in;
   logic [GRID_W-1:0]    grid_y_ff, grid_y_in;
   logic [SCALE_W-1:0]   scale_ff, scale_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 csr_write;

   logic                 q_full;
   logic                 q_push;
   cmd_type              q_push_cmd;
   logic                 q_valid;
   logic                 q_pop;
   cmd_type              q_pop_cmd;

   function automatic logic [GRID_W-1:0] clamp_cells(input logic [GRID_W-1:0] v,
                                                     input int maxv);
      if (v == '0) begin
         clamp_cells = GRID_W'(1);
      end else if (int'(v) > maxv) begin
         clamp_cells = GRID_W'(maxv);
      end else begin
         clamp_cells = v;
      end
   endfunction

   // Register port decode
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      grid_x_in = grid_x_ff;
      grid_y_in = grid_y_ff;
      scale_in  = scale_ff;
      if (csr_write) begin
         unique case (reg_idx)
            REG_GRID_X: grid_x_in = clamp_cells(GRID_W'(csr_pwdata), MAX_CELLS_X);
            REG_GRID_Y: grid_y_in = clamp_cells(GRID_W'(csr_pwdata), MAX_CELLS_Y);
            REG_SCALE:  scale_in  = SCALE_W'(csr_pwdata);
            default:    scale_in  = scale_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_GRID_X: csr_prdata = CSR_DATA_W'(grid_x_ff);
         REG_GRID_Y: csr_prdata = CSR_DATA_W'(grid_y_ff);
         REG_SCALE:  csr_prdata = CSR_DATA_W'(scale_ff);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_x_ff <= clamp_cells(GRID_X_RESET, MAX_CELLS_X);
         grid_y_ff <= clamp_cells(GRID_Y_RESET, MAX_CELLS_Y);
         scale_ff  <= SCALE_RESET;
      end else begin
         grid_x_ff <= grid_x_in;
         grid_y_ff <= grid_y_in;
         scale_ff  <= scale_in;
      end
   end

   hts_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .req      (req_chan),
      .grid_x   (grid_x_ff),
      .grid_y   (grid_y_ff),
      .q_full   (q_full),
      .push     (q_push),
      .push_cmd (q_push_cmd)
   );

   hts_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .pop_cmd  (q_pop_cmd)
   );

   hts_back #(
      .MAX_CELLS_X (MAX_CELLS_X),
      .MAX_CELLS_Y (MAX_CELLS_Y),
      .FRAC_BITS   (FRAC_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .scale   (scale_ff),
      .q_valid (q_valid),
      .q_cmd   (q_pop_cmd),
      .q_pop   (q_pop),
      .rsp     (rsp_chan)
   );

endmodule
